/* rtl/assert_macros.svh */
// Assertion helper macros for the allocator RTL.
// No dependencies; included by the top level only.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define AFA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define AFA_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/afa_pkg.sv */
// Shared types and codes for the aligned first-fit allocator.
// No dependencies; used by the controller, datapath and top level.
package afa_pkg;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_DROP  = 2'd2;
  localparam logic [1:0] ST_RSV   = 2'd3;

  localparam logic REG_POOL_BASE = 1'b0;
  localparam logic REG_POOL_SIZE = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_FSTART, S_FRD, S_FEV, S_MRD, S_MEV, S_MVCHK,
    S_MVRD, S_MVWR, S_INSWR, S_ASTART, S_ARD, S_AEV, S_FIN, S_RESP
  } state_t;

  typedef enum logic [1:0] {RA_IDX, RA_NEXT, RA_MV} ra_sel_t;
  typedef enum logic [1:0] {WR_NONE, WR_MV, WR_INS, WR_CUR} wr_sel_t;
  typedef enum logic [2:0] {
    CUR_HOLD, CUR_NEXT, CUR_PREV, CUR_MERGE, CUR_TRIM, CUR_GAP
  } cur_sel_t;
  typedef enum logic {INS_FREE, INS_REST} ins_sel_t;

  typedef struct packed {
    logic     ld_req;
    logic     ld_pool;
    logic     clr_inst;
    logic     idx_clr;
    logic     idx_inc;
    ra_sel_t  ra;
    wr_sel_t  wr;
    cur_sel_t cur;
    logic     ld_cur;
    logic     ld_ins;
    ins_sel_t ins;
    logic     mv_up_start;
    logic     mv_dn_here;
    logic     mv_dn_next;
    logic     mv_step;
    logic     mv_up;
    logic     cnt_inc;
    logic     cnt_dec;
    logic     set_drop;
    logic     set_grant;
    logic     ld_out;
  } cmd_t;

  typedef struct packed {
    logic is_free;
    logic installed;
    logic inst;
    logic pool_zero;
    logic ovf;
    logic scan_end;
    logic full;
    logic gt;
    logic touch_next;
    logic touch_prev;
    logic has_next;
    logic merge_eq;
    logic fit;
    logic gap0;
    logic newl0;
    logic rest0;
    logic mv_done_up;
    logic mv_done_dn;
    logic out_free;
  } sts_t;

endpackage

/* rtl/afa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module afa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/afa_ctrl.sv */
// Sequencer for the allocator: scan, merge, shift and response steps.
// Depends on afa_pkg; drives the datapath by command struct.
module afa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  afa_pkg::sts_t sts,
  output afa_pkg::cmd_t cmd
);
  import afa_pkg::*;

  state_t state, state_next;
  logic   up, up_next;
  logic   ctx_merge, ctx_merge_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      up        <= 1'b0;
      ctx_merge <= 1'b0;
    end else begin
      state     <= state_next;
      up        <= up_next;
      ctx_merge <= ctx_merge_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next     = state;
    up_next        = up;
    ctx_merge_next = ctx_merge;
    cmd            = '0;
    cmd.mv_up      = up;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.ld_req = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        if (!sts.is_free && !sts.installed) begin
          cmd.ld_pool = 1'b1;
          state_next  = sts.pool_zero ? S_ASTART : S_FSTART;
        end else begin
          state_next = sts.is_free ? S_FSTART : S_ASTART;
        end
      end
      S_FSTART: begin
        cmd.idx_clr = 1'b1;
        state_next  = S_FRD;
      end
      S_FRD: begin
        if (sts.scan_end) begin
          if (sts.full) begin
            cmd.set_drop = !sts.inst;
            state_next   = S_FIN;
          end else begin
            cmd.ld_ins      = 1'b1;
            cmd.ins         = INS_FREE;
            cmd.mv_up_start = 1'b1;
            up_next         = 1'b1;
            state_next      = S_MVCHK;
          end
        end else begin
          cmd.ra     = RA_IDX;
          state_next = S_FEV;
        end
      end
      S_FEV: begin
        if (sts.gt) begin
          if (sts.touch_next) begin
            cmd.cur    = CUR_NEXT;
            cmd.wr     = WR_CUR;
            state_next = S_FIN;
          end else if (sts.full) begin
            cmd.set_drop = !sts.inst;
            state_next   = S_FIN;
          end else begin
            cmd.ld_ins      = 1'b1;
            cmd.ins         = INS_FREE;
            cmd.mv_up_start = 1'b1;
            up_next         = 1'b1;
            state_next      = S_MVCHK;
          end
        end else if (sts.touch_prev) begin
          cmd.cur    = CUR_PREV;
          cmd.ld_cur = 1'b1;
          state_next = S_MRD;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_FRD;
        end
      end
      S_MRD: begin
        if (sts.has_next) begin
          cmd.ra     = RA_NEXT;
          state_next = S_MEV;
        end else begin
          cmd.cur    = CUR_HOLD;
          cmd.wr     = WR_CUR;
          state_next = S_FIN;
        end
      end
      S_MEV: begin
        if (sts.merge_eq) begin
          cmd.cur        = CUR_MERGE;
          cmd.ld_cur     = 1'b1;
          cmd.mv_dn_next = 1'b1;
          up_next        = 1'b0;
          ctx_merge_next = 1'b1;
          state_next     = S_MVCHK;
        end else begin
          cmd.cur    = CUR_HOLD;
          cmd.wr     = WR_CUR;
          state_next = S_FIN;
        end
      end
      S_MVCHK: begin
        if (up) begin
          state_next = sts.mv_done_up ? S_INSWR : S_MVRD;
        end else if (sts.mv_done_dn) begin
          cmd.cnt_dec = 1'b1;
          state_next  = ctx_merge ? S_MRD : S_FIN;
        end else begin
          state_next = S_MVRD;
        end
      end
      S_MVRD: begin
        cmd.ra     = RA_MV;
        state_next = S_MVWR;
      end
      S_MVWR: begin
        cmd.wr      = WR_MV;
        cmd.mv_step = 1'b1;
        state_next  = S_MVCHK;
      end
      S_INSWR: begin
        cmd.wr      = WR_INS;
        cmd.cnt_inc = 1'b1;
        state_next  = S_FIN;
      end
      S_ASTART: begin
        cmd.clr_inst = 1'b1;
        if (sts.ovf) begin
          state_next = S_FIN;
        end else begin
          cmd.idx_clr = 1'b1;
          state_next  = S_ARD;
        end
      end
      S_ARD: begin
        if (sts.scan_end) begin
          state_next = S_FIN;
        end else begin
          cmd.ra     = RA_IDX;
          state_next = S_AEV;
        end
      end
      S_AEV: begin
        if (!sts.fit) begin
          cmd.idx_inc = 1'b1;
          state_next  = S_ARD;
        end else begin
          cmd.set_grant = 1'b1;
          if (sts.gap0) begin
            if (sts.newl0) begin
              cmd.mv_dn_here = 1'b1;
              up_next        = 1'b0;
              ctx_merge_next = 1'b0;
              state_next     = S_MVCHK;
            end else begin
              cmd.cur    = CUR_TRIM;
              cmd.wr     = WR_CUR;
              state_next = S_FIN;
            end
          end else begin
            cmd.cur = CUR_GAP;
            cmd.wr  = WR_CUR;
            if (!sts.rest0 && !sts.full) begin
              cmd.ld_ins      = 1'b1;
              cmd.ins         = INS_REST;
              cmd.idx_inc     = 1'b1;
              cmd.mv_up_start = 1'b1;
              up_next         = 1'b1;
              state_next      = S_MVCHK;
            end else begin
              state_next = S_FIN;
            end
          end
        end
      end
      S_FIN: begin
        state_next = sts.inst ? S_ASTART : S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.ld_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end
endmodule

/* rtl/afa_dp.sv */
// Datapath: segment table RAM, scan/move indexes, operand and result registers.
// Depends on afa_pkg and afa_ram.
module afa_dp #(
  parameter int MAX_SEGMENTS = 32,
  parameter int ALIGNMENT    = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [31:0]   cfg_data,
  input  logic          op,
  input  logic [31:0]   req_size,
  input  logic [31:0]   free_address,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [1:0]    status,
  output logic [31:0]   grant_address,
  output logic [31:0]   grant_size,
  input  afa_pkg::cmd_t cmd,
  output afa_pkg::sts_t sts
);
  import afa_pkg::*;

  localparam int          AW   = $clog2(MAX_SEGMENTS);
  localparam int          IW   = $clog2(MAX_SEGMENTS + 1);
  localparam logic [31:0] MASK = 32'(ALIGNMENT - 1);
  localparam logic [31:0] ALN  = 32'(ALIGNMENT);
  localparam logic [IW:0] MAXC = (IW + 1)'(MAX_SEGMENTS);

  logic [31:0]   pool_base, pool_size;
  logic          op_r, installed, inst;
  logic [31:0]   fa, fs, asz;
  logic          ovf;
  logic [IW-1:0] idx, count, k;
  logic [31:0]   cur_b, cur_l, ins_b, ins_l;
  logic [1:0]    st;
  logic [31:0]   ga, gs;

  logic [63:0]   rdata, wdata;
  logic [AW-1:0] raddr, waddr;
  logic          we;
  logic [31:0]   rd_b, rd_l, gap_raw, gap, avail, rest;
  logic [31:0]   cur_b_next, cur_l_next;
  logic [IW:0]   idx1, k1;
  logic [IW-1:0] ksrc;

  assign rd_b    = rdata[63:32];
  assign rd_l    = rdata[31:0];
  assign gap_raw = rd_b & MASK;
  assign gap     = (gap_raw == 32'd0) ? 32'd0 : ALN - gap_raw;
  assign avail   = rd_l - gap;
  assign rest    = avail - asz;
  assign idx1    = {1'b0, idx} + 1'b1;
  assign k1      = {1'b0, k} + 1'b1;
  assign ksrc    = cmd.mv_up ? (k - 1'b1) : k1[IW-1:0];

  always_comb begin
    cur_b_next = cur_b;
    cur_l_next = cur_l;
    case (cmd.cur)
      CUR_HOLD:  begin cur_b_next = cur_b;       cur_l_next = cur_l;        end
      CUR_NEXT:  begin cur_b_next = fa;          cur_l_next = rd_l + fs;    end
      CUR_PREV:  begin cur_b_next = rd_b;        cur_l_next = rd_l + fs;    end
      CUR_MERGE: begin cur_b_next = cur_b;       cur_l_next = cur_l + rd_l; end
      CUR_TRIM:  begin cur_b_next = rd_b + asz;  cur_l_next = rd_l - asz;   end
      CUR_GAP:   begin cur_b_next = rd_b;        cur_l_next = gap;          end
      default:   begin cur_b_next = cur_b;       cur_l_next = cur_l;        end
    endcase
  end

  always_comb begin
    case (cmd.ra)
      RA_IDX:  raddr = idx[AW-1:0];
      RA_NEXT: raddr = idx1[AW-1:0];
      RA_MV:   raddr = ksrc[AW-1:0];
      default: raddr = idx[AW-1:0];
    endcase
    we    = 1'b0;
    waddr = idx[AW-1:0];
    wdata = {cur_b_next, cur_l_next};
    case (cmd.wr)
      WR_NONE: we = 1'b0;
      WR_MV:   begin we = 1'b1; waddr = k[AW-1:0]; wdata = rdata; end
      WR_INS:  begin we = 1'b1; wdata = {ins_b, ins_l}; end
      WR_CUR:  we = 1'b1;
      default: we = 1'b0;
    endcase
  end

  afa_ram #(.WIDTH(64), .DEPTH(MAX_SEGMENTS)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base <= '0;
      pool_size <= '0;
      installed <= 1'b0;
      inst      <= 1'b0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_POOL_BASE) pool_base <= cfg_data;
        else                            pool_size <= cfg_data;
      end
      if (cmd.ld_pool) begin
        installed <= 1'b1;
        inst      <= 1'b1;
      end else if (cmd.clr_inst) begin
        inst <= 1'b0;
      end
      if (cmd.cnt_inc)      count <= count + 1'b1;
      else if (cmd.cnt_dec) count <= count - 1'b1;
      if (cmd.ld_out)       out_valid <= 1'b1;
      else if (!out_stall)  out_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.ld_req) begin
      op_r <= op;
      fa   <= free_address;
      fs   <= req_size;
      ovf  <= (req_size > ~MASK);
      asz  <= (req_size + MASK) & ~MASK;
      st   <= (op == OP_FREE) ? ST_OK : ST_NOFIT;
      ga   <= '0;
      gs   <= '0;
    end
    if (cmd.ld_pool) begin
      fa <= pool_base;
      fs <= pool_size;
    end
    if (cmd.idx_clr)      idx <= '0;
    else if (cmd.idx_inc) idx <= idx1[IW-1:0];
    if (cmd.ld_cur) begin
      cur_b <= cur_b_next;
      cur_l <= cur_l_next;
    end
    if (cmd.ld_ins) begin
      if (cmd.ins == INS_REST) begin
        ins_b <= rd_b + gap + asz;
        ins_l <= rest;
      end else begin
        ins_b <= fa;
        ins_l <= fs;
      end
    end
    if (cmd.mv_up_start)     k <= count;
    else if (cmd.mv_dn_here) k <= idx;
    else if (cmd.mv_dn_next) k <= idx1[IW-1:0];
    else if (cmd.mv_step)    k <= cmd.mv_up ? (k - 1'b1) : k1[IW-1:0];
    if (cmd.set_drop) st <= ST_DROP;
    if (cmd.set_grant) begin
      st <= ST_OK;
      ga <= rd_b + gap;
      gs <= asz + (((gap != 32'd0) && sts.full) ? rest : 32'd0);
    end
    if (cmd.ld_out) begin
      status        <= st;
      grant_address <= ga;
      grant_size    <= gs;
    end
  end

  always_comb begin
    sts.is_free    = (op_r == OP_FREE);
    sts.installed  = installed;
    sts.inst       = inst;
    sts.pool_zero  = (pool_size == 32'd0);
    sts.ovf        = ovf;
    sts.scan_end   = (idx == count);
    sts.full       = ({1'b0, count} >= MAXC);
    sts.gt         = (rd_b > fa);
    sts.touch_next = ((fa + fs) == rd_b);
    sts.touch_prev = ((rd_b + rd_l) == fa);
    sts.has_next   = (idx1 < {1'b0, count});
    sts.merge_eq   = (rd_b == (cur_b + cur_l));
    sts.fit        = (gap <= rd_l) && (avail >= asz);
    sts.gap0       = (gap == 32'd0);
    sts.newl0      = (rd_l == asz);
    sts.rest0      = (rest == 32'd0);
    sts.mv_done_up = (k == idx);
    sts.mv_done_dn = (k1 >= {1'b0, count});
    sts.out_free   = !out_valid || !out_stall;
  end
endmodule

/* rtl/aligned_first_fit_allocator.sv */
// Top level of the aligned first-fit allocator: controller plus datapath.
// Depends on afa_pkg, afa_ctrl, afa_dp (with afa_ram) and assert_macros.svh.
//
// channel   direction  handshake             payload
// cfg       in         cfg_we                cfg_index, cfg_data
// request   in         in_valid / in_stall   op, req_size, free_address
// response  out        out_valid / out_stall status, grant_address, grant_size
//
// One transaction in flight at a time; the time a request takes grows with each
// scanned segment and each table entry shifted; the first allocate also runs the
// pool insert first, unless the pool size is zero. A free that merges a long run
// of touching segments shifts the table once per merge. Shifts are slow because
// the segment table RAM has one read port with registered data, so they move one
// entry per check/read/write step.
// Reset is synchronous: table count, start-up flag and handshakes clear; the
// table RAM itself is not cleared (only entries below the count are read).
// A finished response sits in the output register while the next request waits
// in idle; out_stall holds that register and keeps the next response in S_RESP.
`include "assert_macros.svh"

module aligned_first_fit_allocator #(
  parameter int MAX_SEGMENTS = 32,
  parameter int ALIGNMENT    = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic [31:0] req_size,
  input  logic [31:0] free_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [31:0] grant_address,
  output logic [31:0] grant_size
);
  import afa_pkg::*;

  cmd_t cmd;   // controller -> datapath strobes and selects
  sts_t sts;   // datapath flags back to the sequencer
  logic grant_zero;

  afa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  afa_dp #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .ALIGNMENT    (ALIGNMENT)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .op            (op),
    .req_size      (req_size),
    .free_address  (free_address),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .grant_address (grant_address),
    .grant_size    (grant_size),
    .cmd           (cmd),
    .sts           (sts)
  );

  assign grant_zero = (grant_address == 32'd0) && (grant_size == 32'd0);

  // an accepted request keeps the input side busy
  `AFA_ASSERT_NXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)
  // reserved status code never leaves the block
  `AFA_ASSERT_IMP(a_no_rsv_status, clk, rst, out_valid, status != ST_RSV)
  // responses with a status other than OK (drop or no fit) carry no grant
  `AFA_ASSERT_IMP(a_no_grant_on_fail, clk, rst, out_valid && status != ST_OK, grant_zero)
endmodule
